FILE: sv/fbs_pkg.sv
`default_nettype none
package fbs_pkg;

  // fixed field widths of the ports
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int IN_W  = 32;
  localparam int POS_W = 10;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/fbs_table.sv
`default_nettype none
module fbs_table #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic signed [VALUE_WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic signed [VALUE_WIDTH-1:0]      rd_data
);

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: sv/fbs_fib.sv
`default_nettype none
module fbs_fib #(
  parameter int DEPTH = 1024,
  parameter int NW    = $clog2(DEPTH + 1),
  parameter int FW    = NW + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [fbs_pkg::LEN_W-1:0] len,
  output logic [NW-1:0]                  n,
  output logic [FW-1:0]                  f,
  output logic [FW-1:0]                  f1,
  output logic [FW-1:0]                  f2,
  output logic                           busy
);
  import fbs_pkg::*;

  localparam int CW = (NW > LEN_W) ? NW : LEN_W;

  logic [CW-1:0] len_ext;
  logic [NW-1:0] n_clamp;

  assign len_ext = CW'(len);
  assign n_clamp = (len_ext > CW'(DEPTH)) ? NW'(DEPTH) : NW'(len_ext);

  // grow the fibonacci triple until it covers the table length, one step a cycle
  assign busy = (f < FW'(n));

  always_ff @(posedge clk) begin
    if (rst) begin
      n  <= '0;
      f2 <= '0;
      f1 <= FW'(1);
      f  <= FW'(1);
    end else if (start) begin
      n  <= n_clamp;
      f2 <= '0;
      f1 <= FW'(1);
      f  <= FW'(1);
    end else if (busy) begin
      f2 <= f1;
      f1 <= f;
      f  <= f1 + f;
    end
  end

endmodule
`default_nettype wire

FILE: sv/fbs_ctrl.sv
`default_nettype none
module fbs_ctrl #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = $clog2(DEPTH),
  parameter int NW          = $clog2(DEPTH + 1),
  parameter int FW          = NW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] key_in,
  input  wire logic [NW-1:0]                 n_in,
  input  wire logic [FW-1:0]                 f_in,
  input  wire logic [FW-1:0]                 f1_in,
  input  wire logic [FW-1:0]                 f2_in,
  output logic [AW-1:0]                      rd_addr,
  input  wire logic signed [VALUE_WIDTH-1:0] rd_data,
  output logic                               idle,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output fbs_pkg::res_t                      res
);
  import fbs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_PROBE_RD  = 6'b000010,
    S_PROBE_CMP = 6'b000100,
    S_LAST_CHK  = 6'b001000,
    S_LAST_CMP  = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t                  state, state_next;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [NW-1:0]           n_r;
  logic [FW-1:0]           f, f1, f2;
  logic [FW-1:0]           f_next, f1_next, f2_next;
  logic [NW-1:0]           base, base_next;
  logic [AW-1:0]           idx;
  logic                    found, found_next;
  logic [POS_W-1:0]        pos, pos_next;

  logic [FW-1:0]           probe_sum;
  logic [AW-1:0]           probe_idx;
  logic [FW-1:0]           diff;

  // probe at offset + f2, clamped to the last entry; base holds offset + 1
  assign probe_sum = FW'(base) + f2 - FW'(1);
  assign probe_idx = (probe_sum >= FW'(n_r)) ? AW'(n_r - NW'(1)) : AW'(probe_sum);
  assign diff      = f1 - f2;

  assign rd_addr   = (state == S_PROBE_RD) ? probe_idx : AW'(base);
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.found    = found;
  assign res.position = pos;

  always_comb begin
    state_next = state;
    f_next     = f;
    f1_next    = f1;
    f2_next    = f2;
    base_next  = base;
    found_next = found;
    pos_next   = pos;
    case (state)
      S_IDLE: begin
        if (start) begin
          f_next     = f_in;
          f1_next    = f1_in;
          f2_next    = f2_in;
          base_next  = '0;
          found_next = 1'b0;
          pos_next   = '0;
          if (n_in == '0) begin
            state_next = S_DONE;
          end else if (f_in > FW'(1)) begin
            state_next = S_PROBE_RD;
          end else begin
            state_next = S_LAST_CHK;
          end
        end
      end
      S_PROBE_RD: begin
        state_next = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (rd_data < key) begin
          f_next    = f1;
          f1_next   = f2;
          f2_next   = diff;
          base_next = NW'(idx) + NW'(1);
        end else if (rd_data > key) begin
          f_next  = f2;
          f1_next = diff;
          f2_next = f2 - diff;
        end
        if (rd_data == key) begin
          found_next = 1'b1;
          pos_next   = POS_W'(idx);
          state_next = S_DONE;
        end else if (f_next > FW'(1)) begin
          state_next = S_PROBE_RD;
        end else begin
          state_next = S_LAST_CHK;
        end
      end
      S_LAST_CHK: begin
        if (f1 != '0 && base < n_r) begin
          state_next = S_LAST_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LAST_CMP: begin
        if (rd_data == key) begin
          found_next = 1'b1;
          pos_next   = POS_W'(base);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    f     <= f_next;
    f1    <= f1_next;
    f2    <= f2_next;
    base  <= base_next;
    found <= found_next;
    pos   <= pos_next;
    if (state == S_IDLE && start) begin
      key <= key_in;
      n_r <= n_in;
    end
    if (state == S_PROBE_RD) begin
      idx <= probe_idx;
    end
  end

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CMP) |-> ($past(state) == S_PROBE_RD))
    else $error("probe compare without a preceding table read");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_RD) |-> (NW'(rd_addr) < n_r))
    else $error("probe address beyond entries in use");

  a_probe_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_RD) |-> (f2 != '0 && f > FW'(1)))
    else $error("probe issued with a spent fibonacci step");

endmodule
`default_nettype wire

FILE: sv/fibonacci_search.sv
`default_nettype none
// Fibonacci search over a sorted table of DEPTH signed entries. A load beat
// (operation 0) writes value into entry entry_index and gives no result;
// indexes at or beyond DEPTH are dropped. A search beat (operation 1)
// looks for value among the first array_length entries (saturated to DEPTH)
// and returns one beat with found and position (position 0 when not found).
// Entries must be loaded before they are searched; the table has no reset.
// Each probe of a search is a table read, then a compare and narrow step;
// there are at most 15 probes for 1024 entries. The final check, the result
// hand-off and the idle state follow before the next beat is taken.
// The block takes no new beat while a search runs.
// Writing array_length starts the fibonacci bound generator, which steps once
// per cycle and holds in_stall high until done. A finished result waits in
// the output register, so a new beat can be taken while the previous result
// is still stalled.
module fibonacci_search #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [fbs_pkg::LEN_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             operation,
  input  wire logic [fbs_pkg::IDX_W-1:0]        entry_index,
  input  wire logic signed [fbs_pkg::IN_W-1:0]  value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  found,
  output logic [fbs_pkg::POS_W-1:0]             position
);
  import fbs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int FW = NW + 1;

  logic                          in_take;
  logic                          wr_en;
  logic signed [VALUE_WIDTH-1:0] value_n;
  logic [AW-1:0]                 rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic [NW-1:0]                 n;
  logic [FW-1:0]                 f, f1, f2;
  logic                          fib_busy;
  logic                          ctrl_idle;
  logic                          res_valid;
  logic                          res_take;
  res_t                          res;

  // sign-extend or truncate the 32-bit field to the table width
  assign value_n  = VALUE_WIDTH'(value);
  assign in_stall = !(ctrl_idle && !fib_busy);
  assign in_take  = in_valid && !in_stall;
  assign wr_en    = in_take && (operation == OP_LOAD) && (32'(entry_index) < 32'(DEPTH));

  fbs_table #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (value_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fbs_fib #(
    .DEPTH (DEPTH),
    .NW    (NW),
    .FW    (FW)
  ) u_fib (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_write),
    .len   (cfg_data),
    .n     (n),
    .f     (f),
    .f1    (f1),
    .f2    (f2),
    .busy  (fib_busy)
  );

  fbs_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .NW          (NW),
    .FW          (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_take && (operation == OP_SEARCH)),
    .key_in    (value_n),
    .n_in      (n),
    .f_in      (f),
    .f1_in     (f1),
    .f2_in     (f2),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register: refill as soon as the slot is empty or being drained
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      found    <= res.found;
      position <= res.position;
    end
  end

  a_out_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(res_take))
    else $error("result beat without a finished search");

endmodule
`default_nettype wire

FILE: tb/sv/fibonacci_search_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module fibonacci_search_tb;
  import fbs_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic signed [IN_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [IN_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  class fib_search_scoreboard;
    logic signed [IN_W-1:0] entries [TABLE_DEPTH];
    logic [LEN_W-1:0] length;
    res_t outcome_q [$];
    int errors;

    function new();
      length = '0;
      errors = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function res_t search_outcome(logic signed [IN_W-1:0] key);
      res_t r;
      int n, offset, i, f2, f1, f;
      r.found = 1'b0;
      r.position = '0;
      n = (length > LEN_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(length);
      if (n == 0) return r;
      f2 = 0;
      f1 = 1;
      f = 1;
      while (f < n) begin
        f2 = f1;
        f1 = f;
        f = f2 + f1;
      end
      offset = -1;
      while (f > 1) begin
        i = offset + f2;
        if (i > n - 1) i = n - 1;
        if (entries[i] < key) begin
          f = f1;
          f1 = f2;
          f2 = f - f1;
          offset = i;
        end else if (entries[i] > key) begin
          f = f2;
          f1 = f1 - f2;
          f2 = f - f1;
        end else begin
          r.found = 1'b1;
          r.position = i[POS_W-1:0];
          return r;
        end
      end
      // last candidate just right of the offset
      if (f1 != 0 && offset + 1 < n && entries[offset + 1] == key) begin
        r.found = 1'b1;
        r.position = POS_W'(offset + 1);
      end
      return r;
    endfunction

    function void note_beat(logic op, logic [IDX_W-1:0] idx, logic signed [IN_W-1:0] val);
      if (op == OP_LOAD) entries[idx] = val;
      else outcome_q.insert(outcome_q.size(), search_outcome(val));
    endfunction

    function void check_outcome(logic f, logic [POS_W-1:0] pos);
      res_t e;
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: found=%0b position=%0d",
                 $time, f, pos);
        return;
      end
      e = outcome_q.pop_front();
      if (f !== e.found || pos !== e.position) begin
        errors++;
        $display("%0t: search mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                 $time, e.found, e.position, f, pos);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_LOAD;
  logic [IDX_W-1:0] entry_index = '0;
  logic signed [IN_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [POS_W-1:0] position;

  fib_search_scoreboard sb;
  bit no_idle = 1'b0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  fibonacci_search dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .entry_index(entry_index),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .position(position)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 22);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_outcome(found, position);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high from one beat to the next unless an idle cycle is drawn
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic signed [IN_W-1:0] val);
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    entry_index <= idx;
    value <= val;
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, idx, val);
    beats_sent++;
  endtask

  task automatic set_length(input logic [LEN_W-1:0] n);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // a trailing load gives no result, so let the block settle
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.length = n;
  endtask

  task automatic run_searches(input int n_eff, input int count);
    int k, j, pick;
    logic signed [IN_W-1:0] key;
    for (k = 0; k < count; k++) begin
      if (k == count / 2 && (n_eff == TABLE_DEPTH || $urandom_range(0, 3) == 0)) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      // stray rewrite inside the prefix, may leave the table unsorted
      if (n_eff > 0 && $urandom_range(0, 19) == 0)
        send_beat(OP_LOAD, IDX_W'($urandom_range(0, n_eff - 1)), $urandom);
      pick = $urandom_range(0, 9);
      j = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
      if (k == 0 && n_eff > 0) key = sb.entries[0];
      else if (k == 1 && n_eff > 0) key = sb.entries[n_eff - 1];
      else if (n_eff == 0 || pick >= 7) key = $urandom;
      else if (pick >= 5) key = sb.entries[j] + ((pick == 5) ? 1 : -1);
      else key = sb.entries[j];
      send_beat(OP_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key);
    end
  endtask

  initial begin
    int n, i, kind, start, stepmax;
    longint v;
    bit scrambled;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table after reset
    send_beat(OP_SEARCH, 10'd0, VAL_MIN);
    send_beat(OP_SEARCH, 10'h3ff, VAL_MAX);
    send_beat(OP_SEARCH, 10'd5, 32'sd0);

    // small table with both extremes and a duplicate
    send_beat(OP_LOAD, 10'd0, VAL_MIN);
    send_beat(OP_LOAD, 10'd1, -32'sd5);
    send_beat(OP_LOAD, 10'd2, 32'sd0);
    send_beat(OP_LOAD, 10'd3, 32'sd3);
    send_beat(OP_LOAD, 10'd4, 32'sd3);
    send_beat(OP_LOAD, 10'd5, 32'sd100);
    send_beat(OP_LOAD, 10'd6, 32'sd2000);
    send_beat(OP_LOAD, 10'd7, VAL_MAX);
    set_length(11'd8);
    send_beat(OP_SEARCH, 10'd0, VAL_MIN);
    send_beat(OP_SEARCH, 10'd0, -32'sd5);
    send_beat(OP_SEARCH, 10'd0, 32'sd3);
    send_beat(OP_SEARCH, 10'd0, 32'sd100);
    send_beat(OP_SEARCH, 10'd0, VAL_MAX);
    send_beat(OP_SEARCH, 10'd0, 32'sd4);
    send_beat(OP_SEARCH, 10'd0, VAL_MIN + 1);
    send_beat(OP_SEARCH, 10'd0, VAL_MAX - 1);
    set_length(11'd1);
    send_beat(OP_SEARCH, 10'd0, VAL_MIN);
    send_beat(OP_SEARCH, 10'd0, 32'sd0);

    // full table, spread over the whole value range, no idling on either side
    no_idle = 1'b1;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      v = longint'(i) * 4194304 + $urandom_range(0, 4194303) - 64'sd2147483648;
      send_beat(OP_LOAD, IDX_W'(i), v[IN_W-1:0]);
    end
    set_length(LEN_W'(TABLE_DEPTH));
    run_searches(TABLE_DEPTH, 20);
    // length above the table saturates
    set_length(11'h7ff);
    run_searches(TABLE_DEPTH, 20);
    no_idle = 1'b0;

    start = beats_sent;
    while (beats_sent - start < 400) begin
      kind = $urandom_range(0, 9);
      n = (kind == 0) ? 0 : (kind == 1) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      scrambled = ($urandom_range(0, 9) == 0);
      stepmax = 1 << $urandom_range(0, 24);
      v = longint'(int'($urandom));
      for (i = 0; i < n; i++) begin
        if (scrambled) send_beat(OP_LOAD, IDX_W'(i), $urandom);
        else send_beat(OP_LOAD, IDX_W'(i), v[IN_W-1:0]);
        v = v + $urandom_range(0, stepmax);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
      end
      set_length(LEN_W'(n));
      run_searches(n, $urandom_range(6, 16));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
